### design/bstr_pkg.sv
// Shared types and constants for the beacon sighting table reporter.
// No dependencies; every other design file imports this package.
package bstr_pkg;

  // Event kinds on the input channel
  localparam logic [1:0] FUNC_ADV     = 2'd0;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd1;
  localparam logic [1:0] FUNC_ADV_END = 2'd2;

  // Result actions
  localparam logic [2:0] ACT_FILTERED = 3'd0;
  localparam logic [2:0] ACT_NEW      = 3'd1;
  localparam logic [2:0] ACT_UPDATED  = 3'd2;
  localparam logic [2:0] ACT_FULL     = 3'd3;
  localparam logic [2:0] ACT_START    = 3'd4;
  localparam logic [2:0] ACT_PING_1ST = 3'd5;
  localparam logic [2:0] ACT_PING     = 3'd6;
  localparam logic [2:0] ACT_REPORT   = 3'd7;

  localparam logic [7:0] TAG_REPORT = 8'h52;
  localparam logic [7:0] TAG_PING   = 8'h54;
  localparam logic [4:0] LEN_PING   = 5'd6;
  localparam logic [4:0] LEN_REPORT = 5'd31;

  localparam logic signed [7:0] STRENGTH_FLOOR = 8'sh80;
  localparam logic [3:0]        PINGS_RESET    = 4'd5;

  typedef enum logic [1:0] {
    CMD_FILTERED,
    CMD_ADV,
    CMD_TIMEOUT,
    CMD_START
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [47:0]        addr;
    logic signed [7:0]  strength;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [1:0]         slot;
    logic [47:0]        addr;
    logic signed [7:0]  strength;
    logic               last;
  } res_t;

  typedef enum logic {
    ST_RUN,
    ST_REPORT
  } st_t;

endpackage

### design/bstr_front.sv
// Front end: accepts input events and classifies them into commands.
// Depends on bstr_pkg; feeds bstr_queue.
module bstr_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_func,
  input  logic [47:0]       in_peer_address,
  input  logic signed [7:0] in_signal_strength,
  input  logic [7:0]        in_tag_byte,
  input  logic [4:0]        in_payload_length,
  input  logic              q_full,
  output logic              push,
  output bstr_pkg::cmd_t    push_cmd
);
  import bstr_pkg::*;

  logic tag_ok;
  logic len_ok;
  logic known;

  assign tag_ok = (in_tag_byte == TAG_REPORT) || (in_tag_byte == TAG_PING);
  assign len_ok = (in_payload_length == LEN_PING) || (in_payload_length == LEN_REPORT);

  always_comb begin
    known             = 1'b1;
    push_cmd.addr     = in_peer_address;
    push_cmd.strength = in_signal_strength;
    unique case (in_func)
      FUNC_ADV:     push_cmd.kind = (tag_ok && len_ok) ? CMD_ADV : CMD_FILTERED;
      FUNC_TIMEOUT: push_cmd.kind = CMD_TIMEOUT;
      FUNC_ADV_END: push_cmd.kind = CMD_START;
      default: begin
        // unknown event kind: take it and drop it
        push_cmd.kind = CMD_FILTERED;
        known         = 1'b0;
      end
    endcase
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full && known;

endmodule

### design/bstr_queue.sv
// Two-entry command queue between front end and table engine.
// Depends on bstr_pkg for the command type.
module bstr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bstr_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output bstr_pkg::cmd_t head_cmd
);
  import bstr_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push;
  logic       do_pop;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_cmd   = q_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

  queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |=> !(cnt_r == 2'd0) || $past(do_pop))
    else $error("queue emptied without a pop");

endmodule

### design/bstr_back.sv
// Table engine: executes commands on the sighting table, ping counter and
// report sequencer, and drives the registered result channel. Uses bstr_pkg.
module bstr_back #(
  parameter int TABLE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [3:0]        cfg_wr_data,
  input  logic              cmd_valid,
  input  bstr_pkg::cmd_t    cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_action,
  output logic [1:0]        out_slot,
  output logic [47:0]       out_entry_address,
  output logic signed [7:0] out_entry_strength,
  output logic              out_last
);
  import bstr_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

  logic [47:0]       addr_r [TABLE_DEPTH];
  logic signed [7:0] str_r  [TABLE_DEPTH];
  logic [3:0]        ping_cnt_r;
  logic [3:0]        ppr_r;
  st_t               st_r, st_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  res_t              res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              out_free;
  logic              report_due;
  logic              start_report;
  logic              emit;
  logic              rep_done;
  logic              hit_found;
  logic              hit_match;
  logic [IDX_W-1:0]  hit_idx;
  logic [IDX_W+1:0]  hit_ext;
  logic [IDX_W+1:0]  idx_ext;

  assign out_free   = !out_valid_r || !out_stall;
  assign report_due = (ping_cnt_r >= ppr_r);
  assign hit_ext    = {2'b00, hit_idx};
  assign idx_ext    = {2'b00, idx_r};

  // First slot that matches or is empty; a match wins within the same slot
  always_comb begin
    hit_found = 1'b0;
    hit_match = 1'b0;
    hit_idx   = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if ((addr_r[i] == cmd.addr) || (addr_r[i] == 48'd0)) begin
        hit_found = 1'b1;
        hit_match = (addr_r[i] == cmd.addr);
        hit_idx   = IDX_W'(i);
      end
    end
  end

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_RUN: begin
        if (start_report) st_nxt = ST_REPORT;
      end
      ST_REPORT: begin
        if (rep_done) st_nxt = ST_RUN;
      end
      default: st_nxt = ST_RUN;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    pop          = 1'b0;
    start_report = 1'b0;
    emit         = 1'b0;
    rep_done     = 1'b0;
    idx_nxt      = idx_r;
    res_nxt      = '0;
    res_nxt.last = 1'b1;
    unique case (st_r)
      ST_RUN: begin
        pop     = cmd_valid && out_free;
        idx_nxt = '0;
        if (pop) begin
          if (cmd.kind == CMD_TIMEOUT && report_due) begin
            start_report = 1'b1;
          end else begin
            emit = 1'b1;
          end
        end
        case (cmd.kind)
          CMD_FILTERED: res_nxt.action = ACT_FILTERED;
          CMD_START:    res_nxt.action = ACT_START;
          CMD_TIMEOUT:  res_nxt.action = (ping_cnt_r == 4'd0) ? ACT_PING_1ST : ACT_PING;
          default: begin
            if (!hit_found) begin
              res_nxt.action = ACT_FULL;
            end else begin
              res_nxt.action = hit_match ? ACT_UPDATED : ACT_NEW;
              res_nxt.slot   = hit_ext[1:0];
            end
          end
        endcase
      end
      ST_REPORT: begin
        emit                = out_free;
        rep_done            = out_free && (idx_r == IDX_LAST);
        res_nxt.action      = ACT_REPORT;
        res_nxt.slot        = idx_ext[1:0];
        res_nxt.addr        = addr_r[idx_r];
        res_nxt.strength    = str_r[idx_r];
        res_nxt.last        = (idx_r == IDX_LAST);
        if (out_free && !rep_done) idx_nxt = idx_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_RUN;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      ping_cnt_r  <= 4'd0;
      ppr_r       <= PINGS_RESET;
    end else begin
      st_r        <= st_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) ppr_r <= cfg_wr_data;
      if (rep_done) begin
        ping_cnt_r <= 4'd0;
      end else if (emit && st_r == ST_RUN && cmd.kind == CMD_TIMEOUT) begin
        ping_cnt_r <= ping_cnt_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) res_r <= res_nxt;
  end

  // Sighting table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        addr_r[i] <= 48'd0;
        str_r[i]  <= STRENGTH_FLOOR;
      end
    end else if (rep_done) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        str_r[i] <= STRENGTH_FLOOR;
      end
    end else if (emit && st_r == ST_RUN && cmd.kind == CMD_ADV && hit_found) begin
      if (!hit_match) begin
        addr_r[hit_idx] <= cmd.addr;
        str_r[hit_idx]  <= cmd.strength;
      end else if (cmd.strength > str_r[hit_idx]) begin
        str_r[hit_idx] <= cmd.strength;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_action         = res_r.action;
  assign out_slot           = res_r.slot;
  assign out_entry_address  = res_r.addr;
  assign out_entry_strength = res_r.strength;
  assign out_last           = res_r.last;

  no_pop_in_report: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_REPORT) |-> !pop)
    else $error("command taken during a report");

  report_items_tagged: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_REPORT && emit) |=> (out_valid && out_action == ACT_REPORT))
    else $error("report entry lost its action");

  report_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    rep_done |=> (st_r == ST_RUN && ping_cnt_r == 4'd0 && out_last))
    else $error("report did not finish cleanly");

  single_results_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action != ACT_REPORT) |-> out_last)
    else $error("single result without last");

endmodule

### design/beacon_sighting_table_reporter_top.sv
// Channel   Direction  Handshake          Payload
// in_*      input      in_valid/in_stall  func, peer_address, signal_strength, tag, length
// out_*     output     out_valid/out_stall action, slot, entry_address, entry_strength, last
// cfg_*     input      cfg_wr_en          cfg_wr_data (pings_per_report)
//
// An event is registered in the queue, then in the table engine's result register;
// single results leave one per cycle from the output register while it is not stalled.
// A report holds the engine for all TABLE_DEPTH slots, one slot per cycle unless stalled.
// Reset is synchronous: table empty, strengths -128, ping count 0, threshold 5.
// A stalled output holds the engine; the two-entry queue keeps taking events
// until it fills. Depends on bstr_pkg, bstr_front, bstr_queue and bstr_back.
module beacon_sighting_table_reporter_top #(
  parameter int TABLE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [3:0]        cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_func,
  input  logic [47:0]       in_peer_address,
  input  logic signed [7:0] in_signal_strength,
  input  logic [7:0]        in_tag_byte,
  input  logic [4:0]        in_payload_length,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_action,
  output logic [1:0]        out_slot,
  output logic [47:0]       out_entry_address,
  output logic signed [7:0] out_entry_strength,
  output logic              out_last
);
  import bstr_pkg::*;

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  bstr_front u_front (
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_peer_address    (in_peer_address),
    .in_signal_strength (in_signal_strength),
    .in_tag_byte        (in_tag_byte),
    .in_payload_length  (in_payload_length),
    .q_full             (q_full),
    .push               (push),
    .push_cmd           (push_cmd)
  );

  bstr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  bstr_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .cmd_valid          (head_valid),
    .cmd                (head_cmd),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_action         (out_action),
    .out_slot           (out_slot),
    .out_entry_address  (out_entry_address),
    .out_entry_strength (out_entry_strength),
    .out_last           (out_last)
  );

endmodule

### test/beacon_sighting_table_reporter_top_test.sv
// Self-checking bench for the beacon sighting table reporter: a queued driver,
// a stall generator and a monitor that predicts every result item in order.
// Depends on bstr_pkg and beacon_sighting_table_reporter_top.
`timescale 1ns / 1ps

module beacon_sighting_table_reporter_top_test;
  import bstr_pkg::*;

  localparam int         TABLE_DEPTH  = 4;
  localparam int         DRAIN_CYCLES = 24;
  localparam int         HOLD_CYCLES  = 150;
  localparam logic [1:0] FUNC_UNUSED  = 2'd3;

  typedef struct {
    logic [1:0]        func;
    logic [47:0]       addr;
    logic signed [7:0] strength;
    logic [7:0]        tag;
    logic [4:0]        len;
  } radio_item_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [3:0]        cfg_wr_data = 4'd0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_func = 2'd0;
  logic [47:0]       in_peer_address = 48'd0;
  logic signed [7:0] in_signal_strength = 8'sd0;
  logic [7:0]        in_tag_byte = 8'd0;
  logic [4:0]        in_payload_length = 5'd0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        out_action;
  logic [1:0]        out_slot;
  logic [47:0]       out_entry_address;
  logic signed [7:0] out_entry_strength;
  logic              out_last;

  beacon_sighting_table_reporter_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_peer_address    (in_peer_address),
    .in_signal_strength (in_signal_strength),
    .in_tag_byte        (in_tag_byte),
    .in_payload_length  (in_payload_length),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_action         (out_action),
    .out_slot           (out_slot),
    .out_entry_address  (out_entry_address),
    .out_entry_strength (out_entry_strength),
    .out_last           (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  radio_item_t pending_items[$];
  res_t        expected_results[$];
  int          items_sent = 0;
  int          items_accepted = 0;
  int          error_count = 0;
  bit          quiet = 1'b0;
  bit          hold_go = 1'b0;

  // Predicted block state
  logic [47:0]       sighting_addr [TABLE_DEPTH];
  logic signed [7:0] sighting_best [TABLE_DEPTH];
  logic [3:0]        pings_seen;
  logic [3:0]        report_threshold;

  function automatic radio_item_t radio_item(input logic [1:0] func, input logic [47:0] addr,
                                             input logic signed [7:0] strength,
                                             input logic [7:0] tag, input logic [4:0] len);
    radio_item_t it;
    it.func     = func;
    it.addr     = addr;
    it.strength = strength;
    it.tag      = tag;
    it.len      = len;
    return it;
  endfunction

  task automatic push_result(input logic [2:0] action, input logic [1:0] slot,
                             input logic [47:0] addr, input logic signed [7:0] strength,
                             input logic last);
    res_t r;
    r.action   = action;
    r.slot     = slot;
    r.addr     = addr;
    r.strength = strength;
    r.last     = last;
    expected_results.push_back(r);
  endtask

  task automatic predict_sighting_results(input radio_item_t it);
    int i;
    bit hit;
    hit = 1'b0;
    case (it.func)
      FUNC_ADV: begin
        if (!((it.tag == TAG_REPORT || it.tag == TAG_PING) &&
              (it.len == LEN_PING || it.len == LEN_REPORT))) begin
          push_result(ACT_FILTERED, 2'd0, 48'd0, 8'sd0, 1'b1);
        end else begin
          // match is tested before emptiness at each slot
          for (i = 0; i < TABLE_DEPTH && !hit; i++) begin
            if (sighting_addr[i] == it.addr) begin
              if (sighting_best[i] < it.strength) sighting_best[i] = it.strength;
              push_result(ACT_UPDATED, 2'(i), 48'd0, 8'sd0, 1'b1);
              hit = 1'b1;
            end else if (sighting_addr[i] == 48'd0) begin
              sighting_addr[i] = it.addr;
              sighting_best[i] = it.strength;
              push_result(ACT_NEW, 2'(i), 48'd0, 8'sd0, 1'b1);
              hit = 1'b1;
            end
          end
          if (!hit) push_result(ACT_FULL, 2'd0, 48'd0, 8'sd0, 1'b1);
        end
      end
      FUNC_TIMEOUT: begin
        if (pings_seen >= report_threshold) begin
          for (i = 0; i < TABLE_DEPTH; i++)
            push_result(ACT_REPORT, 2'(i), sighting_addr[i], sighting_best[i],
                        i == TABLE_DEPTH - 1);
          for (i = 0; i < TABLE_DEPTH; i++) sighting_best[i] = STRENGTH_FLOOR;
          pings_seen = 4'd0;
        end else begin
          push_result((pings_seen == 4'd0) ? ACT_PING_1ST : ACT_PING, 2'd0, 48'd0, 8'sd0,
                      1'b1);
          pings_seen = pings_seen + 4'd1;
        end
      end
      FUNC_ADV_END: push_result(ACT_START, 2'd0, 48'd0, 8'sd0, 1'b1);
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [47:0] want, input logic [47:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Monitor: check result items, predict on accepted input items
  always @(posedge clk) begin : monitor
    res_t want;
    int   i;
    if (!rst_n) begin
      for (i = 0; i < TABLE_DEPTH; i++) begin
        sighting_addr[i] = 48'd0;
        sighting_best[i] = STRENGTH_FLOOR;
      end
      pings_seen       = 4'd0;
      report_threshold = PINGS_RESET;
    end else begin
      if (cfg_wr_en) report_threshold = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result item, action %0d slot %0d", $time, out_action,
                   out_slot);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("action", want.action, out_action);
          check_field("slot", want.slot, out_slot);
          check_field("entry_address", want.addr, out_entry_address);
          check_field("entry_strength", want.strength, out_entry_strength);
          check_field("last", want.last, out_last);
        end
      end
      if (in_valid && !in_stall) begin
        predict_sighting_results(radio_item(in_func, in_peer_address, in_signal_strength,
                                            in_tag_byte, in_payload_length));
        items_accepted <= items_accepted + 1;
      end
    end
  end

  // Driver: advance only once the current item was taken
  always @(negedge clk) begin : driver
    int          gap_left;
    radio_item_t it;
    if (rst_n && items_accepted == items_sent) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        gap_left = $urandom_range(1, 12) - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        in_func            <= it.func;
        in_peer_address    <= it.addr;
        in_signal_strength <= it.strength;
        in_tag_byte        <= it.tag;
        in_payload_length  <= it.len;
        in_valid           <= 1'b1;
        items_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stalls, plus one long hold-off to back up the input
  always @(negedge clk) begin : receiver
    int stall_left;
    int hold_left;
    bit hold_done;
    if (hold_go && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic drain();
    while (pending_items.size() != 0 || items_accepted != items_sent ||
           expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [3:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly well-formed advertisements over a small address pool so that
  // matches, updates and the full table all show up
  task automatic queue_random_items(input int count);
    int          counted;
    int          pick;
    radio_item_t it;
    counted = 0;
    while (counted < count) begin
      pick        = $urandom_range(0, 99);
      it.addr     = {16'($urandom), $urandom};
      it.strength = 8'($urandom);
      it.tag      = 8'($urandom);
      it.len      = 5'($urandom);
      if (pick < 60) begin
        it.func = FUNC_ADV;
        if ($urandom_range(0, 4) != 0) begin
          it.tag = $urandom_range(0, 1) ? TAG_REPORT : TAG_PING;
          it.len = $urandom_range(0, 1) ? LEN_PING : LEN_REPORT;
        end
        case ($urandom_range(0, 9))
          0:       it.addr = 48'h0000_0000_0001;
          1:       it.addr = 48'hFFFF_FFFF_FFFF;
          2, 3:    it.addr = 48'hA5A5_5A5A_C3C3;
          4, 5:    it.addr = 48'h8000_0000_0000;
          6:       it.addr = 48'h1234_5678_9ABC;
          7:       it.addr = 48'd0;
          default: ;
        endcase
      end else if (pick < 85) begin
        it.func = FUNC_TIMEOUT;
      end else if (pick < 93) begin
        it.func = FUNC_ADV_END;
      end else begin
        it.func = FUNC_UNUSED;
      end
      pending_items.push_back(it);
      if (it.func != FUNC_UNUSED) counted++;
    end
  endtask

  initial begin
    int i;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset threshold
    pending_items.push_back(radio_item(FUNC_ADV, 48'd0, -8'sd5, TAG_REPORT, LEN_PING));
    pending_items.push_back(radio_item(FUNC_ADV, 48'h0000_0000_0001, -8'sd128, TAG_PING,
                                       LEN_REPORT));
    pending_items.push_back(radio_item(FUNC_ADV, 48'hFFFF_FFFF_FFFF, 8'sd127, TAG_REPORT,
                                       LEN_REPORT));
    pending_items.push_back(radio_item(FUNC_ADV, 48'hA5A5_5A5A_C3C3, 8'sd0, TAG_PING,
                                       LEN_PING));
    pending_items.push_back(radio_item(FUNC_ADV, 48'hA5A5_5A5A_C3C3, -8'sd1, TAG_PING,
                                       LEN_PING));
    pending_items.push_back(radio_item(FUNC_ADV, 48'hA5A5_5A5A_C3C3, 8'sd100, TAG_REPORT,
                                       LEN_REPORT));
    pending_items.push_back(radio_item(FUNC_ADV, 48'h1, 8'sd1, 8'h53, LEN_PING));
    pending_items.push_back(radio_item(FUNC_ADV, 48'h1, 8'sd1, TAG_REPORT, 5'd5));
    pending_items.push_back(radio_item(FUNC_ADV, 48'h1, 8'sd1, TAG_PING, 5'd0));
    pending_items.push_back(radio_item(FUNC_ADV, 48'h1, 8'sd1, 8'hFF, LEN_REPORT));
    pending_items.push_back(radio_item(FUNC_ADV, 48'h8000_0000_0000, -8'sd128, TAG_PING,
                                       LEN_REPORT));
    pending_items.push_back(radio_item(FUNC_ADV, 48'h1234_5678_9ABC, 8'sd50, TAG_PING,
                                       LEN_PING));
    pending_items.push_back(radio_item(FUNC_ADV, 48'd0, 8'sd127, TAG_REPORT, LEN_PING));
    pending_items.push_back(radio_item(FUNC_ADV_END, 48'd0, 8'sd0, 8'd0, 5'd0));
    pending_items.push_back(radio_item(FUNC_UNUSED, 48'hFFFF_FFFF_FFFF, -8'sd1, 8'hFF,
                                       5'h1F));
    for (i = 0; i < 7; i++)
      pending_items.push_back(radio_item(FUNC_TIMEOUT, 48'd0, 8'sd0, 8'd0, 5'd0));
    pending_items.push_back(radio_item(FUNC_ADV_END, 48'hFFFF_FFFF_FFFF, -8'sd1, 8'hFF,
                                       5'h1F));
    drain();

    // Zero threshold: every timeout reports
    write_threshold(4'd0);
    queue_random_items(40);
    drain();

    // Top threshold, with the long receiver hold-off
    write_threshold(4'd15);
    hold_go = 1'b1;
    queue_random_items(110);
    for (i = 0; i < 8; i++)
      pending_items.push_back(radio_item(FUNC_TIMEOUT, 48'd0, 8'sd0, 8'd0, 5'd0));
    drain();

    // Lower the threshold under the running count
    write_threshold(4'd2);
    queue_random_items(70);
    drain();

    write_threshold(4'd1);
    queue_random_items(60);
    drain();

    write_threshold(4'($urandom_range(2, 14)));
    queue_random_items(80);
    drain();

    // Final stretch with no idling on either side
    write_threshold(4'($urandom_range(0, 15)));
    quiet = 1'b1;
    queue_random_items(80);
    drain();

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### beacon_sighting_table_reporter_top.f
design/bstr_pkg.sv
design/bstr_front.sv
design/bstr_queue.sv
design/bstr_back.sv
design/beacon_sighting_table_reporter_top.sv
test/beacon_sighting_table_reporter_top_test.sv
